// ----- rtl/core/atrc_pkg.sv -----
// Types and constants shared by the AT response checker modules.
package atrc_pkg;

    localparam int HEAD_LEN   = 5;
    localparam int TAIL_DEPTH = 9;
    localparam int OK_TAIL    = 6;
    localparam int ERR_TAIL   = 9;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_BUFFER  = 1'b1;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [7:0] END_OK [OK_TAIL] = '{8'h0D, 8'h0A, 8'h4F, 8'h4B, 8'h0D, 8'h0A};
    localparam logic [7:0] END_ERR [ERR_TAIL] =
        '{8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A};
    localparam logic [7:0] START_OK [2] = '{8'h4F, 8'h4B};
    localparam logic [7:0] START_ERR [HEAD_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ECHO,
        PH_BLANK,
        PH_GATHER
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } res_t;

endpackage

// ----- rtl/core/atrc_in_stage.sv -----
// Input register stage of the AT response checker.
module atrc_in_stage
    import atrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign item_stall = valid_reg && !advance;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.op      <= op;
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- rtl/core/atrc_core.sv -----
// Line splitter, text tracker and response matcher of the AT response checker.
module atrc_core
    import atrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  item_t       item,
    input  logic [15:0] timeout_ticks,
    input  logic [7:0]  buf_cap,
    output res_t        res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  text_len_reg, text_len_next;
    logic [7:0]  line_len_reg, line_len_next;
    logic [7:0]  head_reg [HEAD_LEN];
    logic [7:0]  head_next [HEAD_LEN];
    logic [7:0]  tail_reg [TAIL_DEPTH];
    logic [7:0]  tail_next [TAIL_DEPTH];

    logic [7:0]  app_head [HEAD_LEN];
    logic [7:0]  app_tail [TAIL_DEPTH];
    logic [7:0]  app_text;
    logic [7:0]  app_line;
    logic [15:0] tick_inc;
    logic        full;
    logic        ok_tail, ok_head, err_head, err_tail;

    // appended view of the text for a received byte
    always_comb
    begin
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            app_head[i] = (text_len_reg == 8'(i)) ? item.rx_byte : head_reg[i];
        end
        for (int i = 0; i < TAIL_DEPTH - 1; i++)
        begin
            app_tail[i] = tail_reg[i + 1];
        end
        app_tail[TAIL_DEPTH - 1] = item.rx_byte;
        app_text = text_len_reg + 8'd1;
        app_line = (line_len_reg == 8'hFF) ? line_len_reg : line_len_reg + 8'd1;
        tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
        full     = ({1'b0, text_len_reg} + 9'd1) >= {1'b0, buf_cap};

        ok_tail = (app_text >= 8'(OK_TAIL));
        for (int i = 0; i < OK_TAIL; i++)
        begin
            if (app_tail[TAIL_DEPTH - OK_TAIL + i] != END_OK[i])
            begin
                ok_tail = 1'b0;
            end
        end
        err_tail = (app_text >= 8'(ERR_TAIL));
        for (int i = 0; i < ERR_TAIL; i++)
        begin
            if (app_tail[TAIL_DEPTH - ERR_TAIL + i] != END_ERR[i])
            begin
                err_tail = 1'b0;
            end
        end
        ok_head = (app_text >= 8'd2) && (app_head[0] == START_OK[0])
                  && (app_head[1] == START_OK[1]);
        err_head = (app_text >= 8'(HEAD_LEN));
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            if (app_head[i] != START_ERR[i])
            begin
                err_head = 1'b0;
            end
        end
    end

    always_comb
    begin
        logic do_clear;
        do_clear      = 1'b0;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        text_len_next = text_len_reg;
        line_len_next = line_len_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        res.valid     = 1'b0;
        res.status    = ST_OK;

        if (fire)
        begin
            if (item.op == OP_START)
            begin
                phase_next = PH_ECHO;
                do_clear   = 1'b1;
            end
            else if (phase_reg != PH_IDLE && item.op == OP_TICK)
            begin
                tick_next = tick_inc;
                if (tick_inc >= timeout_ticks)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_TIMEOUT;
                    phase_next = PH_IDLE;
                end
            end
            else if (phase_reg != PH_IDLE && item.op == OP_BYTE)
            begin
                if (full)
                begin
                    if (phase_reg == PH_ECHO)
                    begin
                        phase_next = PH_BLANK;
                        do_clear   = 1'b1;
                    end
                    else
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_OVERFLOW;
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    head_next     = app_head;
                    tail_next     = app_tail;
                    text_len_next = app_text;
                    line_len_next = app_line;
                    if (item.rx_byte == CHAR_LF)
                    begin
                        tick_next = '0;
                        priority if (phase_reg == PH_ECHO)
                        begin
                            phase_next = PH_BLANK;
                            do_clear   = 1'b1;
                        end
                        else if (phase_reg == PH_BLANK && app_line == 8'd2)
                        begin
                            do_clear = 1'b1;
                        end
                        else if (ok_tail || ok_head)
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_OK;
                            phase_next = PH_IDLE;
                        end
                        else if (err_head || err_tail)
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_ERROR;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next    = PH_GATHER;
                            line_len_next = '0;
                        end
                    end
                end
            end
        end

        if (do_clear)
        begin
            tick_next     = '0;
            text_len_next = '0;
            line_len_next = '0;
            for (int i = 0; i < HEAD_LEN; i++)
            begin
                head_next[i] = '0;
            end
            for (int i = 0; i < TAIL_DEPTH; i++)
            begin
                tail_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            text_len_reg <= '0;
            line_len_reg <= '0;
            for (int i = 0; i < HEAD_LEN; i++)
            begin
                head_reg[i] <= '0;
            end
            for (int i = 0; i < TAIL_DEPTH; i++)
            begin
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            text_len_reg <= text_len_next;
            line_len_reg <= line_len_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> phase_reg == PH_IDLE)
        else $error("checker not idle after reporting");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_START |=>
            phase_reg == PH_ECHO && tick_reg == '0 && text_len_reg == '0)
        else $error("start transaction did not clear the text");

    a_line_within_text: assert property (@(posedge clk) disable iff (!rst_n)
        line_len_reg <= text_len_reg)
        else $error("line length exceeds text length");
`endif

endmodule

// ----- rtl/core/at_response_checker_top.sv -----
// Top level of the AT response checker: configuration, input stage, core and result register.
// One transaction is taken per clock cycle unless item_stall holds it back. A result
// passes from its accepted input transaction through the input register, then the result
// register, and is held until taken; the state update for each byte or tick is made
// from the input register. Registers timeout_ticks (index 0) and the buffer capacity
// (index 1) are written through the cfg port, which is always ready, and should be
// changed only while no check is in progress.
module at_response_checker_top
    import atrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] timeout_ticks_reg;
    logic [7:0]  buf_cap_reg;
    logic        result_valid_reg;
    logic [1:0]  status_reg;
    logic        advance;
    logic        held_valid;
    item_t       held_item;
    res_t        res;

    assign cfg_ready = 1'b1;
    assign advance   = !(result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= 16'd20000;
            buf_cap_reg       <= 8'd128;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_ticks_reg <= cfg_data;
                CFG_BUFFER:  buf_cap_reg       <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    atrc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    atrc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (held_valid && advance),
        .item          (held_item),
        .timeout_ticks (timeout_ticks_reg),
        .buf_cap       (buf_cap_reg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            status_reg <= res.status;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;

endmodule

// ----- tb/sv/atrc_tb_pkg.sv -----
// Status predictor and scoreboard for the AT response checker testbench.
package atrc_tb_pkg;
    import atrc_pkg::*;

    localparam logic [1:0] OP_UNDEF = 2'd3;

    class atrc_status_board;
        logic [15:0] timeout_ticks;
        logic [7:0]  buf_cap;
        phase_t      phase;
        logic [15:0] tick_count;
        logic [7:0]  text_length;
        logic [7:0]  line_length;
        logic [7:0]  head_chars [HEAD_LEN];
        logic [7:0]  tail_chars [TAIL_DEPTH];
        logic [1:0]  pending_status [$];
        int          mismatches;
        int          busy_items;
        int          status_count [4];

        function new();
            timeout_ticks = 16'd20000;
            buf_cap       = 8'd128;
            phase         = PH_IDLE;
            mismatches    = 0;
            busy_items    = 0;
            foreach (status_count[i])
                status_count[i] = 0;
            clear_text();
        endfunction

        function void write_reg(logic index, logic [15:0] data);
            if (index == CFG_TIMEOUT)
                timeout_ticks = data;
            else
                buf_cap = data[7:0];
        endfunction

        function void clear_text();
            text_length = 8'd0;
            line_length = 8'd0;
            tick_count  = 16'd0;
            foreach (head_chars[i])
                head_chars[i] = 8'h00;
            foreach (tail_chars[i])
                tail_chars[i] = 8'h00;
        endfunction

        function bit ends_with_ok();
            if (int'(text_length) < OK_TAIL)
                return 1'b0;
            for (int i = 0; i < OK_TAIL; i++)
            begin
                if (tail_chars[TAIL_DEPTH - OK_TAIL + i] != END_OK[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit ends_with_error();
            if (int'(text_length) < ERR_TAIL)
                return 1'b0;
            for (int i = 0; i < ERR_TAIL; i++)
            begin
                if (tail_chars[TAIL_DEPTH - ERR_TAIL + i] != END_ERR[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit starts_with_error();
            if (int'(text_length) < HEAD_LEN)
                return 1'b0;
            for (int i = 0; i < HEAD_LEN; i++)
            begin
                if (head_chars[i] != START_ERR[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void conclude(logic [1:0] st);
            pending_status.push_back(st);
            phase = PH_IDLE;
        endfunction

        // Called for every accepted input transaction.
        function void note_item(logic [1:0] op, logic [7:0] c);
            if (op == OP_START)
            begin
                busy_items++;
                phase = PH_ECHO;
                clear_text();
                return;
            end
            if (phase == PH_IDLE || op == OP_UNDEF)
                return;
            busy_items++;
            if (op == OP_TICK)
            begin
                if (tick_count != 16'hFFFF)
                    tick_count++;
                if (tick_count >= timeout_ticks)
                    conclude(ST_TIMEOUT);
                return;
            end
            if (int'(text_length) + 1 >= int'(buf_cap))
            begin
                // an overlong echo is dropped quietly
                if (phase == PH_ECHO)
                begin
                    phase = PH_BLANK;
                    clear_text();
                end
                else
                    conclude(ST_OVERFLOW);
                return;
            end
            if (int'(text_length) < HEAD_LEN)
                head_chars[text_length] = c;
            for (int i = 0; i < TAIL_DEPTH - 1; i++)
                tail_chars[i] = tail_chars[i + 1];
            tail_chars[TAIL_DEPTH - 1] = c;
            text_length++;
            if (line_length != 8'hFF)
                line_length++;
            if (c != CHAR_LF)
                return;
            tick_count = 16'd0;
            if (phase == PH_ECHO)
            begin
                phase = PH_BLANK;
                clear_text();
                return;
            end
            if (phase == PH_BLANK && line_length == 8'd2)
            begin
                clear_text();
                return;
            end
            if (ends_with_ok() || (text_length >= 8'd2 && head_chars[0] == START_OK[0]
                                   && head_chars[1] == START_OK[1]))
                conclude(ST_OK);
            else if (starts_with_error() || ends_with_error())
                conclude(ST_ERROR);
            else
            begin
                phase       = PH_GATHER;
                line_length = 8'd0;
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [1:0] st);
            logic [1:0] want;
            if (pending_status.size() == 0)
            begin
                report_mismatch($sformatf("result with status %0d and none expected", st));
                return;
            end
            want = pending_status.pop_front();
            status_count[want]++;
            if (st !== want)
                report_mismatch($sformatf("status %0d, expected %0d", st, want));
        endtask
    endclass

endpackage

// ----- tb/sv/tb_at_response_checker_top.sv -----
// Testbench top for at_response_checker_top: stimulus, handshakes and final verdict.
module tb_at_response_checker_top;
    import atrc_pkg::*;
    import atrc_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 250;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    atrc_status_board board;
    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;
    int tick_pct     = 0;
    int cycle_count  = 0;
    int input_stalls = 0;

    logic [15:0] phase_timeout [5] = '{16'd1, 16'd65535, 16'd5, 16'd40, 16'd20000};
    logic [7:0]  phase_buffer  [5] = '{8'd255, 8'd10, 8'd37, 8'd255, 8'd128};

    at_response_checker_top DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (item_valid && item_stall)
            input_stalls++;
        if (rst_n && result_valid && !result_stall)
            board.check_result(status);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** at_response_checker_top: FAILED **");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_stall <= gaps_on && ($urandom_range(0, 99) < 13);
        end
    end

    task automatic send_item(logic [1:0] o, logic [7:0] b);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 99) < 13)
        begin
            item_valid <= 1'b0;
            op         <= 2'($urandom_range(0, 3));
            rx_byte    <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item_valid <= 1'b1;
        op         <= o;
        rx_byte    <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.note_item(o, b);
    endtask

    task automatic put_byte(logic [7:0] b);
        if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct)
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
        send_item(OP_BYTE, b);
    endtask

    task automatic send_line(string s, bit with_cr);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
        if (with_cr)
            put_byte(CHAR_CR);
        put_byte(CHAR_LF);
    endtask

    function automatic logic [7:0] any_char();
        unique case ($urandom_range(0, 9))
            0:       return CHAR_CR;
            1:       return "O";
            2:       return "K";
            3:       return "E";
            4:       return "R";
            5:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic random_line();
        repeat ($urandom_range(0, 8)) put_byte(any_char());
        if ($urandom_range(0, 7) != 0)
            put_byte(CHAR_CR);
        put_byte(CHAR_LF);
    endtask

    task automatic write_cfg(logic index, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(index, data);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Bring any open check to an ok result, then let the pipeline empty.
    task automatic settle_block();
        tick_pct = 0;
        if (board.phase != PH_IDLE)
        begin
            send_item(OP_START, 8'h00);
            send_line("A", 1'b0);
            send_line("OK", 1'b1);
        end
        @(negedge clk) item_valid <= 1'b0;
        while (board.pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One modem answer: echo, blank lines, body and an ending of some kind, or a short run of random transactions.
    task automatic run_response();
        int kind;
        int n;
        tick_pct = ($urandom_range(0, 2) == 0) ? int'($urandom_range(3, 25)) : 0;
        kind = int'($urandom_range(0, 9));
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 8))
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        send_item(OP_START, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
            n = int'(board.buf_cap) + int'($urandom_range(0, 3));
        else
            n = int'($urandom_range(0, 6));
        repeat (n) put_byte(any_char());
        put_byte(CHAR_LF);
        repeat ($urandom_range(0, 2)) send_line("", 1'b1);
        unique case (kind)
            0: send_line("OK", 1'b1);
            1:
            begin
                if ($urandom_range(0, 1) != 0)
                    send_line("ERROR", 1'b1);
                else
                    send_line("ERROR: 4", 1'b1);
            end
            2, 3, 4:
            begin
                repeat ($urandom_range(1, 3)) random_line();
                send_line("OK", 1'b1);
            end
            5:
            begin
                repeat ($urandom_range(1, 3)) random_line();
                send_line("ERROR", 1'b1);
            end
            6:
                repeat (int'(board.buf_cap) + int'($urandom_range(0, 2)))
                    put_byte(8'($urandom_range(32, 126)));
            7:
                repeat ($urandom_range(1, 4)) random_line();
            default:
            begin
                send_line("ERRO", 1'b1);
                send_line("OK", 1'b1);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int target;
        item_valid = 1'b0;
        op         = OP_TICK;
        rx_byte    = 8'h00;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_TIMEOUT;
        cfg_data   = 16'h0000;
        rst_n      = 1'b0;
        board      = new();
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        write_cfg(CFG_TIMEOUT, 16'd3);
        write_cfg(CFG_BUFFER, 16'd10);

        // idle and undefined transactions are ignored
        send_item(OP_UNDEF, 8'hA5);
        send_item(OP_BYTE, 8'h4F);
        send_item(OP_TICK, 8'h00);
        // timeout inside the echo, bytes do not reset the count
        send_item(OP_START, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        repeat (3) send_item(OP_TICK, 8'h5A);
        // restart while busy, blank line skipped, answer starting OK
        send_item(OP_START, 8'h00);
        put_byte("x");
        send_item(OP_START, 8'h81);
        put_byte(CHAR_LF);
        send_line("", 1'b1);
        send_line("OK", 1'b1);
        // answer starting ERROR
        send_item(OP_START, 8'h00);
        put_byte(CHAR_LF);
        send_line("ERROR", 1'b0);

        for (int p = 0; p < 5; p++)
        begin
            settle_block();
            write_cfg(CFG_TIMEOUT, phase_timeout[p]);
            write_cfg(CFG_BUFFER, {8'h00, phase_buffer[p]});
            gaps_on = (p != 2);
            if (p == 0)
                hold_request = 1'b1;
            target = board.busy_items + PHASE_ITEMS;
            while (board.busy_items < target)
                run_response();
        end
        gaps_on = 1'b1;
        settle_block();

        $display("Covered %0d live transactions: %0d ok, %0d timeout, %0d overflow, %0d error.",
                 board.busy_items, board.status_count[ST_OK], board.status_count[ST_TIMEOUT],
                 board.status_count[ST_OVERFLOW], board.status_count[ST_ERROR]);
        $display("Six register settings incl. both extremes; input held back on %0d cycles.",
                 input_stalls);
        if (board.mismatches == 0 && board.pending_status.size() == 0)
            $display("** at_response_checker_top: PASSED **");
        else
            $display("** at_response_checker_top: FAILED **");
        $finish;
    end

endmodule
